@@ hw/rtl/tcsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsa_pkg
// shared types and constants for the three-channel scatter-accumulate block
// ----------------------------------------------------------------------------
package tcsa_pkg;

  localparam int NUM_BINS  = 4096;
  localparam int BIN_W     = 12;
  localparam int ADDR_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int OPND_W    = 24;
  localparam int PROD_W    = 48;
  localparam int SUM_W     = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W    = 2;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t                      cmd;
    logic                      in_range;
    logic [ADDR_W-1:0]         addr;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [PROD_W-1:0]  prod_z;
  } req_t;

  // saturating signed add, flag on clamp
  function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                             input logic signed [PROD_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W+1-PROD_W){b[PROD_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = {1'b1, s[SUM_W], {(SUM_W-1){~s[SUM_W]}}};
    end else begin
      sat_add = {1'b0, s[SUM_W-1:0]};
    end
  endfunction

endpackage

@@ hw/rtl/tcsa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsa_front
// accepts requests, range-checks the bin and forms the three exact products
// ----------------------------------------------------------------------------
module tcsa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [tcsa_pkg::BIN_W-1:0]   bin,
  input  logic signed [tcsa_pkg::OPND_W-1:0] weight,
  input  logic signed [tcsa_pkg::OPND_W-1:0] comp_x,
  input  logic signed [tcsa_pkg::OPND_W-1:0] comp_y,
  input  logic signed [tcsa_pkg::OPND_W-1:0] comp_z,
  output logic                         req_valid,
  input  logic                         req_ready,
  output tcsa_pkg::req_t               req
);
  import tcsa_pkg::*;

  logic [QUEUE_DEPTH-1:0][$bits(req_t)-1:0] q;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  req_t              entry;

  assign in_ready  = (count < (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign req_valid = (count != '0);
  assign pop       = req_valid && req_ready;
  assign req       = req_t'(q[rd_ptr]);

  // classification and products
  always_comb begin
    entry.cmd      = cmd_t'(command);
    entry.in_range = ({4'b0, bin} < 16'(NUM_BINS)) || (NUM_BINS > 65535);
    entry.addr     = ADDR_W'(bin);
    entry.prod_x   = PROD_W'(weight) * PROD_W'(comp_x);
    entry.prod_y   = PROD_W'(weight) * PROD_W'(comp_y);
    entry.prod_z   = PROD_W'(weight) * PROD_W'(comp_z);
  end

  // request queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/tcsa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsa_back
// bin store sequencer: clearing sweep, read-modify-write, result register
// ----------------------------------------------------------------------------
module tcsa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  tcsa_pkg::req_t                req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tcsa_pkg::SUM_W-1:0] sum_x,
  output logic signed [tcsa_pkg::SUM_W-1:0] sum_y,
  output logic signed [tcsa_pkg::SUM_W-1:0] sum_z,
  output logic                          saturated
);
  import tcsa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WB
  } state_t;

  localparam int ROW_W = 3*SUM_W + 1;

  logic [ROW_W-1:0] mem [NUM_BINS];
  logic [ROW_W-1:0] rdata;
  state_t           state;
  logic [ADDR_W:0]  clr_addr;
  req_t             cur;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;
  logic [SUM_W:0]   ax;
  logic [SUM_W:0]   ay;
  logic [SUM_W:0]   az;
  logic             row_sat;

  assign req_ready = (state == ST_IDLE) && !out_valid;

  // saturating channel adds on the stored row
  always_comb begin
    ax      = sat_add(rdata[3*SUM_W:2*SUM_W+1], cur.prod_x);
    ay      = sat_add(rdata[2*SUM_W:SUM_W+1], cur.prod_y);
    az      = sat_add(rdata[SUM_W:1], cur.prod_z);
    row_sat = rdata[0] | ax[SUM_W] | ay[SUM_W] | az[SUM_W];
  end

  // write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur.addr;
    mem_wd = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr[ADDR_W-1:0];
      end
      ST_WB: begin
        mem_we = cur.in_range;
        if (cur.cmd == CMD_ACCUM) begin
          mem_wd = {ax[SUM_W-1:0], ay[SUM_W-1:0], az[SUM_W-1:0], row_sat};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // bin store, row read when the request is taken and held until write back
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state == ST_IDLE) rdata <= mem[req.addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (ADDR_W+1)'(NUM_BINS-1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            cur   <= req;
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_WB;
        ST_WB: begin
          if (cur.cmd == CMD_READ) begin
            out_valid <= 1'b1;
            sum_x     <= cur.in_range ? rdata[3*SUM_W:2*SUM_W+1] : '0;
            sum_y     <= cur.in_range ? rdata[2*SUM_W:SUM_W+1] : '0;
            sum_z     <= cur.in_range ? rdata[SUM_W:1] : '0;
            saturated <= cur.in_range ? rdata[0] : 1'b0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/three_channel_scatter_accumulate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_scatter_accumulate
// three-channel weighted scatter-accumulate into a 4096-bin store
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries command, bin, weight and the
//   three components; command 0 adds weight*comp into the bin's saturating
//   64-bit sums, command 1 returns the bin's sums and flag and clears it.
//   output channel (out_valid/out_ready) carries one result per read.
//   a front stage forms the exact products and parks each request in a
//   four-entry queue; the back stage does read-modify-write on the bin store.
//   the back stage takes one request at a time, through the single-port
//   read-modify-write of the bin store (read, registered data, write back).
//   a read's result is registered at write back and out_valid rises with it.
//   after reset the store is swept to zero over all NUM_BINS (4096) bins;
//   requests queue meanwhile and are served once the sweep ends.
//   a stalled receiver holds the result; the back stage waits, the queue
//   fills and in_ready drops when it is full.
// ----------------------------------------------------------------------------
module three_channel_scatter_accumulate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [tcsa_pkg::BIN_W-1:0]          bin,
  input  logic signed [tcsa_pkg::OPND_W-1:0]  weight,
  input  logic signed [tcsa_pkg::OPND_W-1:0]  comp_x,
  input  logic signed [tcsa_pkg::OPND_W-1:0]  comp_y,
  input  logic signed [tcsa_pkg::OPND_W-1:0]  comp_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tcsa_pkg::SUM_W-1:0]   sum_x,
  output logic signed [tcsa_pkg::SUM_W-1:0]   sum_y,
  output logic signed [tcsa_pkg::SUM_W-1:0]   sum_z,
  output logic                                saturated
);
  import tcsa_pkg::*;

  logic req_valid;
  logic req_ready;
  req_t req;

  // front: accept and classify
  tcsa_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .bin(bin), .weight(weight),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .req_valid(req_valid), .req_ready(req_ready), .req(req)
  );

  // back: bin store update and results
  tcsa_back u_back (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .out_valid(out_valid), .out_ready(out_ready),
    .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z), .saturated(saturated)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for three_channel_scatter_accumulate. A directed table
// covers reset state, operand extremes, same-bin hazards and reads of unused bins.
// Random traffic follows: accumulates and reads, 85 percent on eight hot
// bins and the rest across the whole index range. A bin-store model
// predicts every read result. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_top;
  import tcsa_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct {
    cmd_t               cmd;
    logic [BIN_W-1:0]   bin;
    logic signed [23:0] w;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    bit                 has_known;
    logic signed [63:0] kx;
    logic signed [63:0] ky;
    logic signed [63:0] kz;
    logic               ksat;
  } request_t;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic               sat;
  } bin_sums_t;

  localparam logic signed [23:0] OPND_MAX = 24'sh7fffff;
  localparam logic signed [23:0] OPND_MIN = -24'sh800000;
  localparam logic signed [63:0] SUM_MAX  = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] SUM_MIN  = 64'sh8000000000000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [BIN_W-1:0] bin = '0;
  logic signed [OPND_W-1:0] weight = '0;
  logic signed [OPND_W-1:0] comp_x = '0;
  logic signed [OPND_W-1:0] comp_y = '0;
  logic signed [OPND_W-1:0] comp_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  logic saturated;

  logic signed [63:0] bin_x [NUM_BINS];
  logic signed [63:0] bin_y [NUM_BINS];
  logic signed [63:0] bin_z [NUM_BINS];
  logic               bin_sat [NUM_BINS];

  request_t  direct_rows[$];
  bin_sums_t read_results_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;

  always #5 clk = ~clk;

  three_channel_scatter_accumulate uut (.*);

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // saturating add of one product into a channel sum
  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [47:0] p,
                                                   inout logic sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(p);
    if (s > 65'(SUM_MAX)) begin
      sat = 1'b1;
      return SUM_MAX;
    end
    if (s < 65'(SUM_MIN)) begin
      sat = 1'b1;
      return SUM_MIN;
    end
    return s[63:0];
  endfunction

  // bin store model: update on accumulate, return sums and clear on read
  function automatic void scatter_predict(input request_t r);
    bin_sums_t res;
    bin_sums_t known;
    logic sat;
    int k;
    k = r.bin;
    if (k >= NUM_BINS) begin
      if (r.cmd == CMD_READ) read_results_due.push_back('{0, 0, 0, 1'b0});
      return;
    end
    if (r.cmd == CMD_ACCUM) begin
      sat = 1'b0;
      bin_x[k] = clamp_add(bin_x[k], 48'(r.w) * 48'(r.cx), sat);
      bin_y[k] = clamp_add(bin_y[k], 48'(r.w) * 48'(r.cy), sat);
      bin_z[k] = clamp_add(bin_z[k], 48'(r.w) * 48'(r.cz), sat);
      if (sat) bin_sat[k] = 1'b1;
    end else begin
      res = '{bin_x[k], bin_y[k], bin_z[k], bin_sat[k]};
      known = '{r.kx, r.ky, r.kz, r.ksat};
      if (r.has_known && res != known) begin
        $display("table row disagrees with bin model, bin %0d", k);
        errors++;
      end
      read_results_due.push_back(res);
      bin_x[k] = 0;
      bin_y[k] = 0;
      bin_z[k] = 0;
      bin_sat[k] = 1'b0;
    end
  endfunction

  function automatic request_t row(input cmd_t c, input int b, input int w,
                                   input int x, input int y, input int z);
    request_t r;
    r = '{c, b[BIN_W-1:0], w[23:0], x[23:0], y[23:0], z[23:0], 0, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic request_t read_row(input int b, input logic signed [63:0] x,
                                        input logic signed [63:0] y,
                                        input logic signed [63:0] z,
                                        input logic s);
    request_t r;
    r = row(CMD_READ, b, 0, 0, 0, 0);
    r.has_known = 1;
    r.kx = x;
    r.ky = y;
    r.kz = z;
    r.ksat = s;
    return r;
  endfunction

  // random request focused on a handful of hot bins
  function automatic request_t random_request();
    request_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r = row(($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ACCUM, 0,
            $urandom, $urandom, $urandom, $urandom);
    r.bin = (sel < 85) ? BIN_W'($urandom_range(0, 7)) : BIN_W'($urandom);
    // drive sums towards the bounds now and then
    if (sel >= 95) begin
      r.w = $urandom_range(0, 1) ? OPND_MIN : OPND_MAX;
      r.cx = $urandom_range(0, 1) ? OPND_MIN : OPND_MAX;
      r.cy = r.cx;
      r.cz = $urandom_range(0, 1) ? OPND_MIN : OPND_MAX;
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    command <= r.cmd;
    bin <= r.bin;
    weight <= r.w;
    comp_x <= r.cx;
    comp_y <= r.cy;
    comp_z <= r.cz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scatter_predict(r);
    @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_with_gaps(input request_t r, inout int burst_left);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    send_request(r);
    burst_left--;
  endtask

  // directed table
  initial begin : stimulus
    int burst_left;
    int i;
    request_t r;
    for (i = 0; i < NUM_BINS; i++) begin
      bin_x[i] = 0;
      bin_y[i] = 0;
      bin_z[i] = 0;
      bin_sat[i] = 1'b0;
    end
    // reset state reads zero, at both ends of the bin range
    direct_rows.push_back(read_row(0, 0, 0, 0, 1'b0));
    direct_rows.push_back(read_row(4095, 0, 0, 0, 1'b0));
    // operand extremes, one product on bin 1 and two on bin 4095
    direct_rows.push_back(row(CMD_ACCUM, 1, -8388608, -8388608, 8388607, 0));
    direct_rows.push_back(read_row(1, 64'sd70368744177664, -64'sd70368735789056,
                                   0, 1'b0));
    direct_rows.push_back(row(CMD_ACCUM, 4095, 8388607, 8388607, -8388608, -1));
    direct_rows.push_back(row(CMD_ACCUM, 4095, -1, 1, 1, 1));
    direct_rows.push_back(read_row(4095, 64'sd70368727400448,
                                   -64'sd70368735789057, -64'sd8388608, 1'b0));
    // read after read gives zero
    direct_rows.push_back(read_row(4095, 0, 0, 0, 1'b0));
    // ignored fields on a read
    r = read_row(2, 0, 0, 0, 1'b0);
    r.w = OPND_MIN;
    r.cx = OPND_MAX;
    r.cy = -1;
    r.cz = OPND_MIN;
    direct_rows.push_back(r);
    // back-to-back same-bin hazard
    for (i = 0; i < 4; i++) direct_rows.push_back(row(CMD_ACCUM, 3, 3, i, -i, 7));
    direct_rows.push_back(row(CMD_READ, 3, 0, 0, 0, 0));
    // large positive then negative products on the same bin, short of saturation
    for (i = 0; i < 6; i++) direct_rows.push_back(
      row(CMD_ACCUM, 5, -8388608, -8388608, -8388608, (i < 3) ? -8388608 : 8388607));
    direct_rows.push_back(row(CMD_READ, 5, 0, 0, 0, 0));
    direct_rows.push_back(row(CMD_READ, 5, 0, 0, 0, 0));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = 4;
    foreach (direct_rows[j]) send_with_gaps(direct_rows[j], burst_left);
    for (i = 0; i < RANDOM_ITEMS; i++) send_with_gaps(random_request(), burst_left);
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver stalls in runs of its own
  initial begin : receiver_pattern
    int run;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        run = $urandom_range(1, 12);
        out_ready <= ($urandom_range(0, 2) != 0);
      end
      run--;
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    bin_sums_t want;
    if (!rst && out_valid && out_ready) begin
      if (read_results_due.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = read_results_due.pop_front();
        if (sum_x !== want.x) report_mismatch("sum_x", sum_x, want.x);
        if (sum_y !== want.y) report_mismatch("sum_y", sum_y, want.y);
        if (sum_z !== want.z) report_mismatch("sum_z", sum_z, want.z);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // end of run
  initial begin : finisher
    wait (sending_done);
    while (read_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tcsa_pkg.sv
hw/rtl/tcsa_front.sv
hw/rtl/tcsa_back.sv
hw/rtl/three_channel_scatter_accumulate.sv
tb/tb_top.sv
